// ----- design/modbus_rtu_response_checker_macros.svh -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_macros
// Assertion helpers for the Modbus RTU reply checker.
// ----------------------------------------------------------------------------
// Each macro assumes the signals clock and reset exist in the enclosing module.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MRC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("modbus rtu checker: assertion failed");

// Next-cycle implication, disabled during reset
`define MRC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modbus rtu checker: assertion failed");

`endif

// ----- design/mrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and the CRC-16/MODBUS byte update for the RTU reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

   // Request payload: one received byte of the reply
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
      logic       no_reply;
   } req_payload_type;

   // Result payload: a register word or the end-of-frame status
   typedef struct packed {
      logic        kind;
      logic [6:0]  reg_index;
      logic [15:0] reg_value;
      logic [6:0]  reg_count;
      logic [2:0]  status;
   } rsp_payload_type;

   // Result kinds
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FUNC_MISS  = 3'd1;
   localparam logic [2:0] ST_ADDR_MISS  = 3'd2;
   localparam logic [2:0] ST_NO_REPLY   = 3'd3;
   localparam logic [2:0] ST_CRC_ERROR  = 3'd4;

   // CRC check outcome
   localparam logic [1:0] CRC_NOT_SEEN  = 2'd0;
   localparam logic [1:0] CRC_MATCH     = 2'd1;
   localparam logic [1:0] CRC_MISMATCH  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_SLAVE_ADDRESS     = 1'b0;
   localparam logic CSR_EXPECTED_FUNCTION = 1'b1;

   // Protocol constants
   localparam logic [7:0]  FUNC_READ      = 8'h03;
   localparam logic [7:0]  FUNC_WRITE     = 8'h06;
   localparam logic [8:0]  WRITE_DATA_LEN = 9'd6;
   localparam logic [8:0]  READ_HDR_LEN   = 9'd3;
   localparam logic [8:0]  POS_MAX        = 9'd511;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  ADDR_RESET     = 8'd1;
   localparam logic [7:0]  FUNC_RESET     = 8'd3;

   // One byte of reflected CRC-16/MODBUS, unrolled over eight bits
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- design/modbus_rtu_response_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Byte-wise checker for a Modbus RTU reply: address, function, CRC, words.
// ----------------------------------------------------------------------------
// Takes one reply byte per clock. Each accepted request updates the frame
// state (position, CRC, byte count, match flags) in the same cycle through a
// single unrolled byte-wide CRC step, and any result is captured in one
// output register, valid in the next cycle; the rate is one byte per clock.
// A request is taken whenever the output register is empty or being drained;
// only a stalled pending result holds off the next byte. For function 3 each
// register word appears as soon as its low byte arrives; the frame_end byte
// yields the status and resets the frame state. The user writes configuration
// only while idle via csr_we/csr_index/csr_wdata; the block does not check it.

module modbus_rtu_response_checker
   import mrc_pkg::*;
#(
   parameter int MAX_REGISTERS = 128
) (
   input  wire             clock,
   input  wire             reset,
   // request channel
   input  wire             req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   // result channel
   output logic            rsp_valid,
   input  wire             rsp_stall,
   output rsp_payload_type rsp_data,
   // configuration port
   input  wire             csr_we,
   input  wire             csr_index,
   input  wire [7:0]       csr_wdata
);

   `include "modbus_rtu_response_checker_macros.svh"

   localparam logic [7:0] MaxRegs = 8'(MAX_REGISTERS);

   // Configuration registers
   logic [7:0]  slave_ff, func_ff;

   // Frame state
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  bc_ff, bc_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  crcfirst_ff, crcfirst_in;
   logic        addr_ff, addr_in;
   logic        fn_ff, fn_in;
   logic [1:0]  crcres_ff, crcres_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            result_now;
   rsp_payload_type result;

   // Handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= ADDR_RESET;
         func_ff  <= FUNC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS:     slave_ff <= csr_wdata;
            CSR_EXPECTED_FUNCTION: func_ff  <= csr_wdata;
            default:               ;
         endcase
      end
   end

   // Per-byte frame logic
   always_comb begin
      logic [7:0]  b;
      logic        is_read;
      logic [8:0]  dlen;
      logic [7:0]  half;
      logic [7:0]  limit;
      logic [7:0]  off;
      logic        word_ready;
      logic [2:0]  st;
      logic [6:0]  cnt;

      b          = req_data.rx_byte;
      addr_in    = (pos_ff == 9'd0) ? (b == slave_ff) : addr_ff;
      fn_in      = (pos_ff == 9'd1) ? (b == func_ff) : fn_ff;
      bc_in      = (pos_ff == 9'd2) ? b : bc_ff;
      is_read    = (func_ff == FUNC_READ);
      dlen       = is_read ? (READ_HDR_LEN + {1'b0, bc_in}) : WRITE_DATA_LEN;
      half       = {1'b0, bc_in[7:1]};
      limit      = (half < MaxRegs) ? half : MaxRegs;
      off        = 8'(pos_ff - READ_HDR_LEN);
      word_ready = 1'b0;

      crc_in      = crc_ff;
      pend_in     = pend_ff;
      crcfirst_in = crcfirst_ff;
      crcres_in   = crcres_ff;

      // data, first CRC byte, second CRC byte
      if (pos_ff < dlen) begin
         crc_in = crc16_update(crc_ff, b);
         if (is_read && (pos_ff >= READ_HDR_LEN) && addr_in && fn_in) begin
            if (!off[0]) begin
               pend_in = b;
            end else if ({1'b0, off[7:1]} < limit) begin
               word_ready = 1'b1;
            end
         end
      end else if (pos_ff == dlen) begin
         crcfirst_in = b;
      end else if (pos_ff == (dlen + 9'd1)) begin
         crcres_in = (crc_ff == {b, crcfirst_ff}) ? CRC_MATCH : CRC_MISMATCH;
      end

      pos_in = (pos_ff != POS_MAX) ? (pos_ff + 9'd1) : pos_ff;

      // End-of-frame status, in check order
      cnt = 7'd0;
      if (!addr_in) begin
         st = ST_ADDR_MISS;
      end else if (!fn_in) begin
         st = ST_FUNC_MISS;
      end else if (!is_read && (func_ff != FUNC_WRITE)) begin
         st = ST_ADDR_MISS;
      end else begin
         st = (crcres_in == CRC_MATCH) ? ST_OK : ST_CRC_ERROR;
         if (is_read) begin
            cnt = limit[6:0];
         end
      end

      // Result selection
      result.kind      = KIND_WORD;
      result.reg_index = off[7:1];
      result.reg_value = {pend_ff, b};
      result.reg_count = 7'd0;
      result.status    = ST_OK;
      result_now       = word_ready;
      if (req_data.no_reply) begin
         result.kind      = KIND_STATUS;
         result.reg_index = 7'd0;
         result.reg_value = 16'd0;
         result.status    = ST_NO_REPLY;
         result_now       = 1'b1;
      end else if (req_data.frame_end) begin
         result.kind      = KIND_STATUS;
         result.reg_index = 7'd0;
         result.reg_value = 16'd0;
         result.reg_count = cnt;
         result.status    = st;
         result_now       = 1'b1;
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 9'd0;
         crc_ff      <= CRC_INIT;
         bc_ff       <= 8'd0;
         pend_ff     <= 8'd0;
         crcfirst_ff <= 8'd0;
         addr_ff     <= 1'b0;
         fn_ff       <= 1'b0;
         crcres_ff   <= CRC_NOT_SEEN;
      end else if (accept) begin
         if (req_data.no_reply || req_data.frame_end) begin
            pos_ff      <= 9'd0;
            crc_ff      <= CRC_INIT;
            bc_ff       <= 8'd0;
            pend_ff     <= 8'd0;
            crcfirst_ff <= 8'd0;
            addr_ff     <= 1'b0;
            fn_ff       <= 1'b0;
            crcres_ff   <= CRC_NOT_SEEN;
         end else begin
            pos_ff      <= pos_in;
            crc_ff      <= crc_in;
            bc_ff       <= bc_in;
            pend_ff     <= pend_in;
            crcfirst_ff <= crcfirst_in;
            addr_ff     <= addr_in;
            fn_ff       <= fn_in;
            crcres_ff   <= crcres_in;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept && result_now) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `MRC_ASSERT_IMP(a_word_clean, rsp_valid_ff && (rsp_data_ff.kind == KIND_WORD), (rsp_data_ff.status == ST_OK) && (rsp_data_ff.reg_count == 7'd0))
   `MRC_ASSERT_NXT(a_no_reply_status, accept && req_data.no_reply, rsp_valid_ff && (rsp_data_ff.kind == KIND_STATUS) && (rsp_data_ff.status == ST_NO_REPLY))
   `MRC_ASSERT_NXT(a_end_clears, accept && (req_data.frame_end || req_data.no_reply), (pos_ff == 9'd0) && (crc_ff == CRC_INIT) && (crcres_ff == CRC_NOT_SEEN))
   `MRC_ASSERT_NXT(a_pos_advance, accept && !req_data.frame_end && !req_data.no_reply && (pos_ff != POS_MAX), pos_ff == ($past(pos_ff) + 9'd1))
   `MRC_ASSERT_IMP(a_word_needs_match, rsp_valid_ff && (rsp_data_ff.kind == KIND_WORD) && !$past(req_stall), $past(addr_in) && $past(fn_in))

endmodule
`default_nettype wire

// ----- tb/modbus_reply_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_reply_scoreboard
// Watches the RTU reply checker's channels and predicts every result.
// ----------------------------------------------------------------------------
// Follows the configuration writes and every accepted request, keeps its own
// copy of the frame state (position, running CRC, byte count, match flags)
// and queues the register words and end-of-frame statuses the block owes.
// Each accepted result is compared field by field with the oldest one owed.
// The number of mismatches and of results still owed go to the top.

module modbus_reply_scoreboard
   import mrc_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   input  wire             req_stall,
   input  req_payload_type req_data,
   input  wire             rsp_valid,
   input  wire             rsp_stall,
   input  rsp_payload_type rsp_data,
   input  wire             csr_we,
   input  wire             csr_index,
   input  wire [7:0]       csr_wdata,
   output int              mismatch_count,
   output int              results_owed
);

   // Configuration as the block should see it
   logic [7:0]  slave_addr;
   logic [7:0]  func_code;

   // Frame state
   logic [8:0]  position;
   logic [15:0] crc_run;
   logic [7:0]  byte_count;
   logic [7:0]  high_byte;
   logic [7:0]  crc_low;
   logic        addr_seen_ok;
   logic        func_seen_ok;
   logic [1:0]  crc_check;

   rsp_payload_type owed_results[$];
   int failures = 0;

   assign mismatch_count = failures;

   // Reflected CRC-16, one bit per pass
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   function automatic rsp_payload_type status_result(input logic [2:0] st,
                                                     input logic [6:0] cnt);
      rsp_payload_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.reg_count = cnt;
      r.status = st;
      return r;
   endfunction

   task automatic clear_frame();
      position = '0;
      crc_run = CRC_INIT;
      byte_count = '0;
      high_byte = '0;
      crc_low = '0;
      addr_seen_ok = 1'b0;
      func_seen_ok = 1'b0;
      crc_check = CRC_NOT_SEEN;
   endtask

   // One request: update the frame state and queue what it causes
   task automatic predict_reply_byte(input req_payload_type rq);
      logic [8:0]      data_len;
      logic [8:0]      off;
      logic [6:0]      word_limit;
      logic [2:0]      st;
      logic            word_due;
      rsp_payload_type word;
      if (rq.no_reply) begin
         owed_results.push_back(status_result(ST_NO_REPLY, 7'd0));
         clear_frame();
         return;
      end
      word_due = 1'b0;
      word = '0;
      case (position)
         9'd0: addr_seen_ok = (rq.rx_byte == slave_addr);
         9'd1: func_seen_ok = (rq.rx_byte == func_code);
         9'd2: byte_count = rq.rx_byte;
         default: ;
      endcase
      // count / 2 is at most 127, so the 128-word cap never binds
      word_limit = byte_count[7:1];
      data_len = (func_code == FUNC_READ) ? READ_HDR_LEN + {1'b0, byte_count}
                                          : WRITE_DATA_LEN;
      if (position < data_len) begin
         crc_run = crc_step(crc_run, rq.rx_byte);
         if (func_code == FUNC_READ && position >= READ_HDR_LEN
             && addr_seen_ok && func_seen_ok) begin
            off = position - READ_HDR_LEN;
            if (!off[0]) begin
               high_byte = rq.rx_byte;
            end else if (off[7:1] < word_limit) begin
               word_due = 1'b1;
               word.kind = KIND_WORD;
               word.reg_index = off[7:1];
               word.reg_value = {high_byte, rq.rx_byte};
            end
         end
      end else if (position == data_len) begin
         crc_low = rq.rx_byte;
      end else if (position == data_len + 9'd1) begin
         crc_check = ({rq.rx_byte, crc_low} == crc_run) ? CRC_MATCH : CRC_MISMATCH;
      end
      if (position < POS_MAX) position = position + 9'd1;

      // frame_end wins over a word completed on the same byte
      if (rq.frame_end) begin
         if (!addr_seen_ok) st = ST_ADDR_MISS;
         else if (!func_seen_ok) st = ST_FUNC_MISS;
         else if (func_code != FUNC_READ && func_code != FUNC_WRITE) st = ST_ADDR_MISS;
         else st = (crc_check == CRC_MATCH) ? ST_OK : ST_CRC_ERROR;
         owed_results.push_back(status_result(st,
            (addr_seen_ok && func_seen_ok && func_code == FUNC_READ) ? word_limit : 7'd0));
         clear_frame();
      end else if (word_due) begin
         owed_results.push_back(word);
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (owed_results.size() == 0) begin
         $error("result with none owed: kind %0d index %0d value %h count %0d status %0d",
                got.kind, got.reg_index, got.reg_value, got.reg_count, got.status);
         failures++;
         return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         failures++;
      end
      if (got.reg_index !== want.reg_index) begin
         $error("reg_index: expected %0d, got %0d", want.reg_index, got.reg_index);
         failures++;
      end
      if (got.reg_value !== want.reg_value) begin
         $error("reg_value: expected %h, got %h", want.reg_value, got.reg_value);
         failures++;
      end
      if (got.reg_count !== want.reg_count) begin
         $error("reg_count: expected %0d, got %0d", want.reg_count, got.reg_count);
         failures++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         failures++;
      end
   endtask

   // Everything is sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         slave_addr = ADDR_RESET;
         func_code = FUNC_RESET;
         clear_frame();
         owed_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SLAVE_ADDRESS) slave_addr = csr_wdata;
            else func_code = csr_wdata;
         end
         if (req_valid && !req_stall) predict_reply_byte(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      results_owed <= owed_results.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Modbus RTU reply checker.
// ----------------------------------------------------------------------------
// Feeds a few hand-made replies at the reset configuration, then runs
// through several address/function settings with random replies: mostly
// well-formed frames with random content, plus wrong addresses and codes,
// broken CRCs, cut-off frames, trailing bytes, aborted frames and line
// noise. The sender works in bursts, the receiver stalls on its own
// changing pattern with a periodic long hold. The scoreboard does the
// checking; this module only reports the outcome.

module testbench;
   import mrc_pkg::*;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we = 1'b0;
   logic            csr_index = CSR_SLAVE_ADDRESS;
   logic [7:0]      csr_wdata = '0;
   int              mismatch_count;
   int              results_owed;

   // Current settings and sender bookkeeping
   logic [7:0] cur_addr = ADDR_RESET;
   logic [7:0] cur_func = FUNC_RESET;
   int         requests_sent = 0;
   int         burst_left = 0;
   logic [7:0] frame_buf[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   modbus_rtu_response_checker #(
      .MAX_REGISTERS(128)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   modbus_reply_scoreboard scoreboard (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .results_owed(results_owed)
   );

   // One request; valid stays high afterwards so a burst runs back to back
   task automatic send_request(input logic [7:0] b, input logic fe, input logic nr);
      req_payload_type rq;
      rq.rx_byte = b;
      rq.frame_end = fe;
      rq.no_reply = nr;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= rq;
      requests_sent++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop sending and wait until every owed result is out
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (results_owed != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] addr, input logic [7:0] func);
      csr_we <= 1'b1;
      csr_index <= CSR_SLAVE_ADDRESS;
      csr_wdata <= addr;
      @(negedge clock);
      csr_index <= CSR_EXPECTED_FUNCTION;
      csr_wdata <= func;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_addr = addr;
      cur_func = func;
   endtask

   // CRC low byte first, then high byte
   task automatic append_crc();
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (frame_buf[i]) crc = crc16_update(crc, frame_buf[i]);
      frame_buf.push_back(crc[7:0]);
      frame_buf.push_back(crc[15:8]);
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_request(frame_buf[i], i == frame_buf.size() - 1, 1'b0);
   endtask

   // Full-size read reply followed by enough junk to saturate the position
   task automatic send_overlong_frame();
      frame_buf = '{cur_addr, FUNC_READ, 8'hFF};
      repeat (255) frame_buf.push_back(8'($urandom));
      append_crc();
      repeat (260) frame_buf.push_back(8'($urandom));
      send_frame();
   endtask

   task automatic send_random_frame();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      // line noise, no_reply and frame_end anywhere
      if (pick < 6) begin
         repeat ($urandom_range(1, 12))
            send_request(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 9) == 0);
         return;
      end
      frame_buf.delete();
      frame_buf.push_back((pick < 16) ? cur_addr + 8'($urandom_range(1, 255)) : cur_addr);
      frame_buf.push_back((pick >= 16 && pick < 26) ? cur_func + 8'($urandom_range(1, 255))
                                                    : cur_func);
      if (cur_func == FUNC_READ) begin
         // mostly short replies, now and then up to the full byte count
         count = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
         frame_buf.push_back(8'(count));
         repeat (count) frame_buf.push_back(8'($urandom));
      end else begin
         repeat (4) frame_buf.push_back(8'($urandom));
      end
      append_crc();
      if (pick >= 26 && pick < 36) begin
         // one bit wrong in the received CRC
         count = frame_buf.size() - 1 - $urandom_range(0, 1);
         frame_buf[count] = frame_buf[count] ^ (8'd1 << $urandom_range(0, 7));
      end else if (pick >= 36 && pick < 46) begin
         repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
      end else if (pick >= 46 && pick < 54) begin
         repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom));
      end
      if (pick >= 54 && pick < 59) begin
         // window closes part way through
         repeat ($urandom_range(0, frame_buf.size() - 1)) void'(frame_buf.pop_back());
         foreach (frame_buf[i]) send_request(frame_buf[i], 1'b0, 1'b0);
         send_request(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
         send_frame();
      end
   endtask

   // Receiver: changing stall pattern plus a periodic long hold
   initial begin : receiver
      int             cyc;
      int             hold;
      int             mode_left;
      stall_mode_type mode;
      cyc = 0;
      hold = 0;
      mode_left = 0;
      mode = STALL_NONE;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 5000 == 1200) hold = 120;
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default:     rsp_stall <= (cyc % 4 == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int phase;
      int phase_start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: address 1, function 3
      // no reply on an idle line
      send_request(8'hFF, 1'b0, 1'b1);
      // clean read of two words, data at both extremes
      frame_buf = '{ADDR_RESET, FUNC_READ, 8'h04, 8'h00, 8'hFF, 8'hFF, 8'h00};
      append_crc();
      send_frame();
      // cut after the function code, CRC never seen
      frame_buf = '{ADDR_RESET, FUNC_READ};
      send_frame();
      // no reply in the middle of a frame, with frame_end also set
      send_request(ADDR_RESET, 1'b0, 1'b0);
      send_request(FUNC_READ, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
      // frame ends on the byte that completes a word: status only
      frame_buf = '{ADDR_RESET, FUNC_READ, 8'h02, 8'h12, 8'h34};
      send_frame();
      // a single byte with the wrong address
      send_request(8'h00, 1'b1, 1'b0);

      // Random replies under several settings
      for (phase = 0; phase < 8; phase++) begin
         drain_results();
         case (phase)
            0: configure(8'h00, FUNC_READ);
            1: configure(8'hFF, FUNC_WRITE);
            2: configure(8'h5A, FUNC_READ);
            3: configure(8'h00, 8'h10);
            4: configure(8'hFF, 8'h00);
            5: configure(8'h80, 8'hFF);
            6: configure(8'($urandom), FUNC_WRITE);
            default: configure(8'($urandom), FUNC_READ);
         endcase
         if (phase == 7) send_overlong_frame();
         phase_start = requests_sent;
         while (requests_sent - phase_start < 155) begin
            send_random_frame();
            if ($urandom_range(0, 14) == 0) drain_results();
         end
      end

      drain_results();
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
